// ===== rtl/core/sbxks_pkg.sv =====
// Shared constants and table helpers for the single-byte XOR key search.
`default_nettype none

package sbxks_pkg;

    localparam int unsigned SCORE_W  = 22;
    localparam int unsigned KEY_W    = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FREQ_N   = 27;
    localparam int unsigned FREQ_IDX_W = 5;

    localparam logic [SCORE_W-1:0] SCORE_SAT = {SCORE_W{1'b1}};
    localparam logic [KEY_W-1:0]   KEY_FIRST = 8'd1;
    localparam logic [KEY_W-1:0]   KEY_LAST  = 8'd255;

    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_GAP   = 8'd32;

    // English letter frequencies in units of 1e-7: space, then a..z
    localparam logic [31:0] FREQ_E7 [FREQ_N] = '{
        32'd1918182,
        32'd651738, 32'd124248, 32'd217339, 32'd349835, 32'd1041442, 32'd197881,
        32'd158610, 32'd492888, 32'd558094, 32'd9033, 32'd50529, 32'd331490,
        32'd202124, 32'd564513, 32'd596302, 32'd137645, 32'd8606, 32'd497563,
        32'd515760, 32'd729357, 32'd225134, 32'd82903, 32'd171272, 32'd13692,
        32'd145984, 32'd7836
    };

    // Elaboration-time conversion to unsigned fixed point, round half up
    function automatic logic [SCORE_W-1:0] freq_value(input int unsigned idx,
                                                       input int unsigned fbits);
        logic [63:0] v;
        v = 64'(FREQ_E7[idx]) << fbits;
        return SCORE_W'((v + 64'd5000000) / 64'd10000000);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbxks_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbxks_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/single_byte_xor_key_search.sv =====
// Top level: buffers a message and finds the single-byte XOR key with the best English score.
// Bytes are taken one per cycle while the block is idle and written into a message RAM of
// MAX_MESSAGE entries; bytes past capacity are dropped and reported through overflowed. The
// beat with last_byte set starts the search: keys 1 to 255 are tried in turn, and for each key
// every stored byte is read back once, XORed, case-folded and scored from a 27-entry frequency
// table into one saturating 22-bit accumulator. One RAM read and one add happen per cycle, and
// in_stall stays high after the last beat until every key has been scored, longer if the
// previous result is still waiting to be taken from the output register.
// The result then sits in an output register, so the next message can be taken while it waits.
`default_nettype none

module single_byte_xor_key_search #(
    parameter int unsigned MAX_MESSAGE         = 256,
    parameter int unsigned SCORE_FRACTION_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           last_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          best_key,
    output logic [sbxks_pkg::SCORE_W-1:0]       best_score,
    output logic                                key_found,
    output logic                                overflowed
);

    import sbxks_pkg::*;

    localparam int unsigned ADDR_W = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_MESSAGE + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE);

    localparam logic [SCORE_W-1:0] FREQ_Q [FREQ_N] = '{
        freq_value(0,  SCORE_FRACTION_BITS), freq_value(1,  SCORE_FRACTION_BITS),
        freq_value(2,  SCORE_FRACTION_BITS), freq_value(3,  SCORE_FRACTION_BITS),
        freq_value(4,  SCORE_FRACTION_BITS), freq_value(5,  SCORE_FRACTION_BITS),
        freq_value(6,  SCORE_FRACTION_BITS), freq_value(7,  SCORE_FRACTION_BITS),
        freq_value(8,  SCORE_FRACTION_BITS), freq_value(9,  SCORE_FRACTION_BITS),
        freq_value(10, SCORE_FRACTION_BITS), freq_value(11, SCORE_FRACTION_BITS),
        freq_value(12, SCORE_FRACTION_BITS), freq_value(13, SCORE_FRACTION_BITS),
        freq_value(14, SCORE_FRACTION_BITS), freq_value(15, SCORE_FRACTION_BITS),
        freq_value(16, SCORE_FRACTION_BITS), freq_value(17, SCORE_FRACTION_BITS),
        freq_value(18, SCORE_FRACTION_BITS), freq_value(19, SCORE_FRACTION_BITS),
        freq_value(20, SCORE_FRACTION_BITS), freq_value(21, SCORE_FRACTION_BITS),
        freq_value(22, SCORE_FRACTION_BITS), freq_value(23, SCORE_FRACTION_BITS),
        freq_value(24, SCORE_FRACTION_BITS), freq_value(25, SCORE_FRACTION_BITS),
        freq_value(26, SCORE_FRACTION_BITS)
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic                 issue_on_reg;
    logic [KEY_W-1:0]     issue_key_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 pipe_valid_reg;
    logic                 pipe_end_reg;
    logic [KEY_W-1:0]     pipe_key_reg;
    logic [SCORE_W-1:0]   running_reg;
    logic [SCORE_W-1:0]   leading_reg;
    logic [KEY_W-1:0]     leading_key_reg;
    logic                 out_valid_reg;
    logic [KEY_W-1:0]     best_key_reg;
    logic [SCORE_W-1:0]   best_score_reg;
    logic                 key_found_reg;
    logic                 overflowed_reg;

    logic                 in_fire;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]     count_m1;
    logic                 idx_end;
    logic [BYTE_W-1:0]    plain;
    logic [BYTE_W-1:0]    folded;
    logic                 letter_hit;
    logic [FREQ_IDX_W-1:0] letter_idx;
    logic [SCORE_W-1:0]   byte_pts;
    logic [SCORE_W:0]     sum_wide;
    logic [SCORE_W-1:0]   sum_sat;
    logic                 out_load;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign ram_we   = in_fire && (count_reg < CNT_MAX);

    sbxks_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_MESSAGE)
    ) u_msg_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(data_byte),
        .raddr(rd_idx_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_end  = (rd_idx_reg == count_m1);

    // Decrypt, fold upper case, look up the score of the byte read last cycle and add it with saturation
    always_comb
    begin
        plain  = ram_rdata ^ pipe_key_reg;
        folded = plain;
        if (plain >= CH_UPPER_A && plain <= CH_UPPER_Z)
        begin
            folded = plain + CASE_GAP;
        end
        letter_hit = 1'b0;
        letter_idx = '0;
        if (folded == CH_SPACE)
        begin
            letter_hit = 1'b1;
        end
        else if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z)
        begin
            letter_hit = 1'b1;
            letter_idx = FREQ_IDX_W'(folded - CH_LOWER_A) + FREQ_IDX_W'(1);
        end
        byte_pts = letter_hit ? FREQ_Q[letter_idx] : '0;
        sum_wide = {1'b0, running_reg} + {1'b0, byte_pts};
        sum_sat  = sum_wide[SCORE_W] ? SCORE_SAT : sum_wide[SCORE_W-1:0];
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            issue_on_reg    <= 1'b0;
            issue_key_reg   <= '0;
            rd_idx_reg      <= '0;
            pipe_valid_reg  <= 1'b0;
            pipe_end_reg    <= 1'b0;
            pipe_key_reg    <= '0;
            running_reg     <= '0;
            leading_reg     <= '0;
            leading_key_reg <= '0;
            out_valid_reg   <= 1'b0;
            best_key_reg    <= '0;
            best_score_reg  <= '0;
            key_found_reg   <= 1'b0;
            overflowed_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (count_reg < CNT_MAX)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_byte)
                        begin
                            leading_reg     <= '0;
                            leading_key_reg <= '0;
                            running_reg     <= '0;
                            issue_key_reg   <= KEY_FIRST;
                            rd_idx_reg      <= '0;
                            issue_on_reg    <= 1'b1;
                            pipe_valid_reg  <= 1'b0;
                            state_reg       <= ST_RUN;
                        end
                    end
                end

                ST_RUN:
                begin
                    // the accumulator works on each read in the cycle after it is issued
                    pipe_valid_reg <= issue_on_reg;
                    pipe_end_reg   <= idx_end;
                    pipe_key_reg   <= issue_key_reg;
                    if (issue_on_reg)
                    begin
                        if (idx_end)
                        begin
                            rd_idx_reg <= '0;
                            if (issue_key_reg == KEY_LAST)
                            begin
                                issue_on_reg <= 1'b0;
                            end
                            else
                            begin
                                issue_key_reg <= issue_key_reg + KEY_W'(1);
                            end
                        end
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                        end
                    end

                    if (pipe_valid_reg)
                    begin
                        if (pipe_end_reg)
                        begin
                            running_reg <= '0;
                            // strictly higher only: the earliest key keeps a tie
                            if (sum_sat > leading_reg)
                            begin
                                leading_reg     <= sum_sat;
                                leading_key_reg <= pipe_key_reg;
                            end
                            if (pipe_key_reg == KEY_LAST)
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        else
                        begin
                            running_reg <= sum_sat;
                        end
                    end
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        best_key_reg   <= leading_key_reg;
                        best_score_reg <= leading_reg;
                        key_found_reg  <= (leading_reg != '0);
                        overflowed_reg <= ovf_reg;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_key   = best_key_reg;
    assign best_score = best_score_reg;
    assign key_found  = key_found_reg;
    assign overflowed = overflowed_reg;

endmodule

`default_nettype wire

// ===== tb/single_byte_xor_key_search_test.sv =====
// Testbench for single_byte_xor_key_search: directed and random messages, local key scorer.
`timescale 1ns / 100ps

module single_byte_xor_key_search_test;

    import sbxks_pkg::SCORE_W;

    localparam int unsigned MSG_CAPACITY = 256;
    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned SCORE_MAX    = (1 << SCORE_W) - 1;
    localparam int unsigned RANDOM_BYTES = 500;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned MAX_IDLE     = 17;

    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] FOLD_OFFSET   = 8'd32;

    typedef struct packed {
        logic [7:0]         key;
        logic [SCORE_W-1:0] score;
        logic               found;
        logic               ovf;
    } key_verdict_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         data_byte = 8'h00;
    logic               last_byte = 1'b0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [7:0]         best_key;
    logic [SCORE_W-1:0] best_score;
    logic               key_found;
    logic               overflowed;

    // English frequencies in units of 1e-7: space first, then a..z
    int unsigned letter_freq_e7 [27] = '{
        1918182,
        651738, 124248, 217339, 349835, 1041442, 197881, 158610,
        492888, 558094, 9033, 50529, 331490, 202124, 564513,
        596302, 137645, 8606, 497563, 515760, 729357, 225134,
        82903, 171272, 13692, 145984, 7836
    };

    string plain_pool = "the quick brown fox jumps over a lazy dog ETAOIN SHRDLU Cwm";

    logic [7:0]   held_message [$];
    bit           held_overflow;
    key_verdict_t expected_verdicts [$];

    bit          send_quiet;
    bit          recv_quiet;
    int unsigned fail_count;
    int unsigned bytes_taken;
    int unsigned messages_taken;
    int unsigned verdicts_checked;
    int unsigned overflow_messages;
    int unsigned cycle_count;

    single_byte_xor_key_search #(
        .MAX_MESSAGE         (MSG_CAPACITY),
        .SCORE_FRACTION_BITS (FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_key   (best_key),
        .best_score (best_score),
        .key_found  (key_found),
        .overflowed (overflowed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned idle_cycles(input bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic int unsigned letter_weight(input logic [7:0] ch);
        logic [7:0]  c;
        int unsigned idx;
        c = ch;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
            c = c + FOLD_OFFSET;
        if (c == ASCII_SPACE)
            idx = 0;
        else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
            idx = c - ASCII_LOWER_A + 1;
        else
            return 0;
        // Q0.16 with round half up
        return int'((longint'(letter_freq_e7[idx]) * (longint'(1) << FRAC_BITS)
                     + 64'd5000000) / 64'd10000000);
    endfunction

    // Sweep keys 1..255 over the held message; first strictly higher score wins
    function automatic key_verdict_t best_key_search();
        key_verdict_t v;
        int unsigned  total;
        int unsigned  leading;
        int unsigned  k;
        v       = '0;
        leading = 0;
        for (k = 1; k <= 255; k++)
        begin
            total = 0;
            foreach (held_message[i])
            begin
                total += letter_weight(held_message[i] ^ k[7:0]);
                if (total > SCORE_MAX)
                    total = SCORE_MAX;
            end
            if (total > leading)
            begin
                leading = total;
                v.key   = k[7:0];
            end
        end
        v.score = leading[SCORE_W-1:0];
        v.found = (leading > 0);
        v.ovf   = held_overflow;
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int unsigned gap;
        gap = idle_cycles(send_quiet);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        bytes_taken++;
        if (held_message.size() < MSG_CAPACITY)
            held_message.push_back(value);
        else
            held_overflow = 1'b1;
        if (is_last)
        begin
            expected_verdicts.push_back(best_key_search());
            if (held_overflow)
                overflow_messages++;
            messages_taken++;
            held_message.delete();
            held_overflow = 1'b0;
        end
    endtask

    task automatic send_text(input string text, input logic [7:0] key);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(text[i] ^ key, i == text.len() - 1);
    endtask

    task automatic send_random_message(input int unsigned len, input bit plain);
        logic [7:0]  key;
        int unsigned i;
        logic [7:0]  b;
        key = 8'($urandom_range(0, 255));
        for (i = 1; i <= len; i++)
        begin
            if (plain)
                b = plain_pool[$urandom_range(0, plain_pool.len() - 1)] ^ key;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len);
        end
    endtask

    task automatic test_lone_bytes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h20, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_short_phrases();
        send_text("Hi there", 8'hFF);
        // upper and lower case score alike, so the lower key must win the tie
        send_text("ZAP", 8'h01);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b1);
    endtask

    task automatic test_capacity_edge();
        send_random_message(MSG_CAPACITY, 1'b1);
        // one past capacity: the closing beat itself is dropped
        send_random_message(MSG_CAPACITY + 1, 1'b0);
        send_random_message(MSG_CAPACITY + 2, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned start_bytes;
        int unsigned len;
        start_bytes = bytes_taken;
        while (bytes_taken - start_bytes < RANDOM_BYTES)
        begin
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(25, 64);
            else
                len = $urandom_range(1, 24);
            send_random_message(len, $urandom_range(0, 9) < 7);
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    initial
    begin : verdict_checker
        key_verdict_t want;
        int unsigned  hold;
        forever
        begin
            hold = idle_cycles(recv_quiet);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (expected_verdicts.size() == 0)
            begin
                $error("Result beat with nothing expected: key %0d score %0d",
                       best_key, best_score);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (best_key !== want.key)
                begin
                    $error("best_key: expected %0d, got %0d", want.key, best_key);
                    fail_count++;
                end
                if (best_score !== want.score)
                begin
                    $error("best_score: expected %0d, got %0d", want.score, best_score);
                    fail_count++;
                end
                if (key_found !== want.found)
                begin
                    $error("key_found: expected %0d, got %0d", want.found, key_found);
                    fail_count++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed: expected %0d, got %0d", want.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lone_bytes();
        test_short_phrases();
        test_capacity_edge();
        test_random_traffic();

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        // catch any stray result beat
        repeat (64) @(posedge clk);

        $display("Sent %0d bytes in %0d messages, %0d of them over capacity",
                 bytes_taken, messages_taken, overflow_messages);
        $display("Checked %0d key search results in %0d cycles", verdicts_checked, cycle_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sbxks_pkg.sv
rtl/core/sbxks_ram.sv
rtl/core/single_byte_xor_key_search.sv
tb/single_byte_xor_key_search_test.sv
